[sv/rhh_pkg.sv]
// Shared operation and status codes for the Robin Hood hash table.
package rhh_pkg;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_FIND   = 2'd1,
    FN_REMOVE = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_FULL      = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  localparam logic [10:0] FILL_LIMIT_RST = 11'd512;

endpackage

[sv/rhh_mem.sv]
// Slot memory: one write port, one registered read port.
module rhh_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int W     = 75
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/rhh_home.sv]
// Home slot unit: key_hash modulo the slot count, one restoring step per cycle.
module rhh_home #(
  parameter int SLOTS = 1024,
  parameter int SW    = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   hash,
  output logic          done,
  output logic [SW-1:0] home
);

  localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam int KMAX = 33 - SW;
  localparam int DW   = 34;
  localparam int KW   = 6;
  localparam logic [DW-1:0] DIV_TOP = DW'(SLOTS) << KMAX;

  logic [31:0]   rem_r;
  logic [DW-1:0] div_r;
  logic [KW-1:0] k_r;
  logic          busy_r;
  logic          done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= hash;
        div_r <= DIV_TOP;
        k_r   <= KW'(KMAX);
        if (POW2) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        // subtract the shifted divisor when it fits
        if ({2'b00, rem_r} >= div_r) begin
          rem_r <= 32'({2'b00, rem_r} - div_r);
        end
        div_r <= div_r >> 1;
        if (k_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          k_r <= k_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign home = rem_r[SW-1:0];

endmodule

[sv/robin_hood_hash_table_top.sv]
// Robin Hood hash table: probe sequencer over one slot memory and a home slot unit.
// A request finds its home slot (restoring division unless SLOTS is a power of 2),
//   then reads and checks each probed slot; remove also rewrites each shifted slot.
// Clear sweeps every slot. One request at a time; busy stays high meanwhile.
// Reset (rst_n low, synchronous) starts a sweep that empties every slot;
//   busy is high during it. Results strobe on out_valid for one cycle, never stalled.
module robin_hood_hash_table_top import rhh_pkg::*; #(
  parameter int SLOTS      = 1024,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_key,
  input  logic [31:0] in_key_hash,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_value_out,
  output logic [9:0]  out_slot,
  output logic [10:0] out_fill_count,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = 1 + SW + VALUE_BITS + KEY_BITS;
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);
  localparam logic [SW:0]   NLAST = (SW + 1)'(SLOTS - 1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_SWEEP   = 10'b0000000010,
    S_HASH    = 10'b0000000100,
    S_LOC_RD  = 10'b0000001000,
    S_LOC_CHK = 10'b0000010000,
    S_INS_RD  = 10'b0000100000,
    S_INS_CHK = 10'b0001000000,
    S_REM_RD  = 10'b0010000000,
    S_REM_CHK = 10'b0100000000,
    S_REM_END = 10'b1000000000
  } state_t;

  state_t                state_r;
  func_t                 func_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [KEY_BITS-1:0]   ck_r;
  logic [VALUE_BITS-1:0] cv_r;
  logic [SW-1:0]         i_r;
  logic [SW-1:0]         prev_r;
  logic [SW-1:0]         land_r;
  logic [SW:0]           n_r;
  logic [SW:0]           d_r;
  logic                  placed_r;
  logic                  clr_rpt_r;
  logic [CW-1:0]         cnt_r;
  logic [10:0]           cfg_fill_limit_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [31:0]           out_value_r;
  logic [SW-1:0]         out_slot_r;

  logic                  accept;
  logic                  home_done;
  logic [SW-1:0]         home;
  logic                  rd_en;
  logic                  wr_en;
  logic [SW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;
  logic [EW-1:0]         rd_data;

  logic                  e_used;
  logic [SW-1:0]         e_dist;
  logic [VALUE_BITS-1:0] e_val;
  logic [KEY_BITS-1:0]   e_key;
  logic [SW-1:0]         i_step;
  logic                  full;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign e_used = rd_data[EW-1];
  assign e_dist = rd_data[EW-2 -: SW];
  assign e_val  = rd_data[KEY_BITS +: VALUE_BITS];
  assign e_key  = rd_data[KEY_BITS-1:0];
  assign i_step = (i_r == LAST) ? '0 : i_r + 1'b1;
  assign full   = (32'(cnt_r) >= 32'(cfg_fill_limit_r)) || (32'(cnt_r) >= 32'(SLOTS));

  rhh_home #(.SLOTS(SLOTS), .SW(SW)) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .hash  (in_key_hash),
    .done  (home_done),
    .home  (home)
  );

  rhh_mem #(.DEPTH(SLOTS), .AW(SW), .W(EW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (i_r),
    .rd_data (rd_data)
  );

  assign rd_en = (state_r == S_LOC_RD) || (state_r == S_INS_RD) || (state_r == S_REM_RD);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i_r;
    wr_data = '0;
    case (state_r)
      S_SWEEP: begin
        wr_en = 1'b1;
      end
      S_LOC_CHK: begin
        // update in place
        if (func_r == FN_INSERT && e_used && e_key == key_r) begin
          wr_en   = 1'b1;
          wr_data = {1'b1, e_dist, val_r, e_key};
        end
      end
      S_INS_CHK: begin
        if (!e_used || ((SW + 1)'(e_dist) < d_r)) begin
          wr_en   = 1'b1;
          wr_data = {1'b1, d_r[SW-1:0], cv_r, ck_r};
        end
      end
      S_REM_CHK: begin
        wr_en   = 1'b1;
        wr_addr = prev_r;
        if (e_used && e_dist != '0) begin
          wr_data = {1'b1, e_dist - 1'b1, e_val, e_key};
        end
      end
      S_REM_END: begin
        wr_en   = 1'b1;
        wr_addr = prev_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_SWEEP;
      i_r              <= '0;
      clr_rpt_r        <= 1'b0;
      cnt_r            <= '0;
      cfg_fill_limit_r <= FILL_LIMIT_RST;
      out_valid_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr_en) begin
        cfg_fill_limit_r <= cfg_wr_data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r <= func_t'(in_func);
            key_r  <= KEY_BITS'(in_key);
            val_r  <= VALUE_BITS'(in_value);
            if (func_t'(in_func) == FN_CLEAR) begin
              i_r       <= '0;
              clr_rpt_r <= 1'b1;
              state_r   <= S_SWEEP;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_SWEEP: begin
          if (i_r == LAST) begin
            state_r <= S_IDLE;
            cnt_r   <= '0;
            if (clr_rpt_r) begin
              clr_rpt_r    <= 1'b0;
              out_valid_r  <= 1'b1;
              out_status_r <= ST_CLEARED;
              out_value_r  <= '0;
              out_slot_r   <= '0;
            end
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_HASH: begin
          if (home_done) begin
            i_r     <= home;
            n_r     <= '0;
            state_r <= S_LOC_RD;
          end
        end
        S_LOC_RD: begin
          state_r <= S_LOC_CHK;
        end
        S_LOC_CHK: begin
          if (e_used && e_key == key_r) begin
            land_r <= i_r;
            case (func_r)
              FN_INSERT: begin
                state_r      <= S_IDLE;
                out_valid_r  <= 1'b1;
                out_status_r <= ST_UPDATED;
                out_value_r  <= '0;
                out_slot_r   <= i_r;
              end
              FN_FIND: begin
                state_r      <= S_IDLE;
                out_valid_r  <= 1'b1;
                out_status_r <= ST_FOUND;
                out_value_r  <= 32'(e_val);
                out_slot_r   <= i_r;
              end
              default: begin
                if (cnt_r != '0) begin
                  cnt_r <= cnt_r - 1'b1;
                end
                prev_r  <= i_r;
                i_r     <= i_step;
                n_r     <= '0;
                state_r <= S_REM_RD;
              end
            endcase
          end else if (!e_used || ((SW + 1)'(e_dist) < n_r) || n_r == NLAST) begin
            // key absent
            if (func_r == FN_INSERT && !full) begin
              i_r      <= i_r - SW'(n_r) + ((SW'(n_r) > i_r) ? SW'(SLOTS) : '0);
              d_r      <= '0;
              n_r      <= '0;
              ck_r     <= key_r;
              cv_r     <= val_r;
              placed_r <= 1'b0;
              state_r  <= S_INS_RD;
            end else begin
              state_r      <= S_IDLE;
              out_valid_r  <= 1'b1;
              out_status_r <= (func_r == FN_INSERT) ? ST_FULL : ST_NOT_FOUND;
              out_value_r  <= '0;
              out_slot_r   <= '0;
            end
          end else begin
            i_r     <= i_step;
            n_r     <= n_r + 1'b1;
            state_r <= S_LOC_RD;
          end
        end
        S_INS_RD: begin
          state_r <= S_INS_CHK;
        end
        S_INS_CHK: begin
          if (!e_used) begin
            cnt_r        <= cnt_r + 1'b1;
            state_r      <= S_IDLE;
            out_valid_r  <= 1'b1;
            out_status_r <= ST_INSERTED;
            out_value_r  <= '0;
            out_slot_r   <= placed_r ? land_r : i_r;
          end else begin
            if ((SW + 1)'(e_dist) < d_r) begin
              // swap with the richer resident
              if (!placed_r) begin
                land_r   <= i_r;
                placed_r <= 1'b1;
              end
              ck_r <= e_key;
              cv_r <= e_val;
              d_r  <= (SW + 1)'(e_dist) + 1'b1;
            end else begin
              d_r <= d_r + 1'b1;
            end
            i_r <= i_step;
            n_r <= n_r + 1'b1;
            if (n_r == NLAST) begin
              state_r      <= S_IDLE;
              out_valid_r  <= 1'b1;
              out_status_r <= ST_INSERTED;
              out_value_r  <= '0;
              out_slot_r   <= placed_r ? land_r : i_r;
            end else begin
              state_r <= S_INS_RD;
            end
          end
        end
        S_REM_RD: begin
          state_r <= S_REM_CHK;
        end
        S_REM_CHK: begin
          if (!e_used || e_dist == '0) begin
            state_r      <= S_IDLE;
            out_valid_r  <= 1'b1;
            out_status_r <= ST_REMOVED;
            out_value_r  <= '0;
            out_slot_r   <= land_r;
          end else begin
            prev_r <= i_r;
            i_r    <= i_step;
            n_r    <= n_r + 1'b1;
            if (n_r == NLAST) begin
              state_r <= S_REM_END;
            end else begin
              state_r <= S_REM_RD;
            end
          end
        end
        S_REM_END: begin
          state_r      <= S_IDLE;
          out_valid_r  <= 1'b1;
          out_status_r <= ST_REMOVED;
          out_value_r  <= '0;
          out_slot_r   <= land_r;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value_out  = out_value_r;
  assign out_slot       = 10'(out_slot_r);
  assign out_fill_count = 11'(cnt_r);

endmodule

[tb/testbench.sv]
// Self-checking testbench for the Robin Hood hash table: a scoreboard of predicted results.
`timescale 1ns / 100ps

module testbench;
  import rhh_pkg::*;

  typedef struct {
    func_t       op;
    logic [31:0] key;
    logic [31:0] hash;
    logic [31:0] value;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] value;
    logic [9:0]  slot;
    logic [10:0] fill;
  } response_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = '0;
  logic [31:0] in_key = '0;
  logic [31:0] in_key_hash = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_value_out;
  logic [9:0]  out_slot;
  logic [10:0] out_fill_count;
  logic        cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;

  robin_hood_hash_table_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_key(in_key), .in_key_hash(in_key_hash), .in_value(in_value),
    .out_valid(out_valid), .out_status(out_status), .out_value_out(out_value_out),
    .out_slot(out_slot), .out_fill_count(out_fill_count),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Mirror of the table contents
  logic        tbl_used [1024];
  logic [31:0] tbl_key [1024];
  logic [31:0] tbl_value [1024];
  logic [9:0]  tbl_dist [1024];
  int          tbl_count;
  logic [10:0] tbl_limit;

  request_t    request_q[$];
  response_t   response_q[$];
  logic        req_taken = 1'b0;
  int          error_count = 0;
  int          status_seen [7];
  int          gap_left = 0;
  int          burst_left = 0;
  logic [31:0] pool_key [64];
  logic [31:0] pool_hash [64];
  int          pool_size;

  function automatic bit find_slot(input logic [31:0] k, input logic [9:0] home,
                                   output logic [9:0] pos);
    logic [9:0] i;
    int d;
    i = home;
    d = 0;
    pos = '0;
    for (int n = 0; n < 1024; n++) begin
      if (!tbl_used[i]) return 1'b0;
      if (tbl_key[i] == k) begin
        pos = i;
        return 1'b1;
      end
      if (int'(tbl_dist[i]) < d) return 1'b0;
      d++;
      i = i + 10'd1;
    end
    return 1'b0;
  endfunction

  function automatic void empty_table();
    for (int i = 0; i < 1024; i++) begin
      tbl_used[i] = 1'b0;
      tbl_dist[i] = '0;
    end
    tbl_count = 0;
  endfunction

  function automatic response_t apply_request(input request_t r);
    response_t   rsp;
    logic [9:0]  home, pos, i, prev;
    logic [31:0] ck, cv, tk, tv;
    logic [9:0]  td;
    int          d;
    bit          placed;
    home = r.hash[9:0];
    rsp.status = ST_NOT_FOUND;
    rsp.value = '0;
    rsp.slot = '0;
    case (r.op)
      FN_INSERT: begin
        if (find_slot(r.key, home, pos)) begin
          tbl_value[pos] = r.value;
          rsp.status = ST_UPDATED;
          rsp.slot = pos;
        end else if (tbl_count >= int'(tbl_limit) || tbl_count >= 1024) begin
          rsp.status = ST_FULL;
        end else begin
          i = home;
          d = 0;
          placed = 0;
          ck = r.key;
          cv = r.value;
          for (int n = 0; n < 1024; n++) begin
            if (!tbl_used[i]) begin
              tbl_used[i] = 1'b1;
              tbl_key[i] = ck;
              tbl_value[i] = cv;
              tbl_dist[i] = d[9:0];
              if (!placed) rsp.slot = i;
              tbl_count++;
              break;
            end
            // swap the carried entry with a richer resident
            if (int'(tbl_dist[i]) < d) begin
              tk = tbl_key[i];
              tv = tbl_value[i];
              td = tbl_dist[i];
              if (!placed) begin
                rsp.slot = i;
                placed = 1;
              end
              tbl_key[i] = ck;
              tbl_value[i] = cv;
              tbl_dist[i] = d[9:0];
              ck = tk;
              cv = tv;
              d = td;
            end
            d++;
            i = i + 10'd1;
          end
          rsp.status = ST_INSERTED;
        end
      end
      FN_FIND: begin
        if (find_slot(r.key, home, pos)) begin
          rsp.status = ST_FOUND;
          rsp.value = tbl_value[pos];
          rsp.slot = pos;
        end
      end
      FN_REMOVE: begin
        if (find_slot(r.key, home, pos)) begin
          tbl_used[pos] = 1'b0;
          tbl_dist[pos] = '0;
          if (tbl_count > 0) tbl_count--;
          prev = pos;
          i = pos + 10'd1;
          // shift the following cluster back by one
          for (int n = 0; n < 1024; n++) begin
            if (!tbl_used[i] || tbl_dist[i] == 0) break;
            tbl_key[prev] = tbl_key[i];
            tbl_value[prev] = tbl_value[i];
            tbl_dist[prev] = tbl_dist[i] - 10'd1;
            tbl_used[prev] = 1'b1;
            tbl_used[i] = 1'b0;
            tbl_dist[i] = '0;
            prev = i;
            i = i + 10'd1;
          end
          rsp.status = ST_REMOVED;
          rsp.slot = pos;
        end
      end
      default: begin
        empty_table();
        rsp.status = ST_CLEARED;
      end
    endcase
    rsp.fill = tbl_count[10:0];
    return rsp;
  endfunction

  // Scoreboard: check results, predict on each accepted request, track the limit
  always @(posedge clk) begin
    response_t want;
    request_t  req;
    if (out_valid) begin
      if (response_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, out_status);
        error_count++;
      end else begin
        want = response_q.pop_front();
        if (out_status != want.status || out_value_out != want.value ||
            out_slot != want.slot || out_fill_count != want.fill) begin
          $display("%0t: mismatch expected status=%0d value=%h slot=%0d fill=%0d",
                   $time, want.status, want.value, want.slot, want.fill);
          $display("%0t:          actual   status=%0d value=%h slot=%0d fill=%0d",
                   $time, out_status, out_value_out, out_slot, out_fill_count);
          error_count++;
        end
        status_seen[want.status]++;
      end
    end
    if (rst_n && cfg_wr_en) tbl_limit = cfg_wr_data;
    if (rst_n && start && !busy) begin
      req.op = func_t'(in_func);
      req.key = in_key;
      req.hash = in_key_hash;
      req.value = in_value;
      response_q.push_back(apply_request(req));
    end
    req_taken <= rst_n && start && !busy;
  end

  // Request driver: bursts of random length, random gaps between them
  always @(negedge clk) begin
    request_t r;
    if (rst_n && !(start && !req_taken)) begin
      if (gap_left > 0 || request_q.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        r = request_q.pop_front();
        start <= 1'b1;
        in_func <= r.op;
        in_key <= r.key;
        in_key_hash <= r.hash;
        in_value <= r.value;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
      end
    end
  end

  task automatic push_req(input func_t op, input logic [31:0] k, input logic [31:0] h,
                          input logic [31:0] v);
    request_t r;
    r.op = op;
    r.key = k;
    r.hash = h;
    r.value = v;
    request_q.push_back(r);
  endtask

  task automatic wait_idle();
    wait (request_q.size() == 0 && !start && response_q.size() == 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_limit(input logic [10:0] lim);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lim;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Keys with home slots within spread of one random base, so probe chains get long
  task automatic make_pool(input int n, input int spread);
    logic [9:0] base;
    base = $urandom_range(0, 1023);
    pool_size = n;
    for (int i = 0; i < n; i++) begin
      pool_key[i] = $urandom;
      pool_hash[i] = {22'($urandom_range(0, 22'h3fffff)),
                      10'(base + $urandom_range(0, spread))};
    end
  endtask

  task automatic random_requests(input int n);
    int p, sel;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, pool_size - 1);
      sel = $urandom_range(0, 199);
      if ($urandom_range(0, 9) == 0)
        push_req(func_t'($urandom_range(0, 2)), $urandom, $urandom, $urandom);
      else if (sel == 0)
        push_req(FN_CLEAR, $urandom, $urandom, $urandom);
      else if (sel < 90)
        push_req(FN_INSERT, pool_key[p], pool_hash[p], $urandom);
      else if (sel < 150)
        push_req(FN_FIND, pool_key[p], pool_hash[p], $urandom);
      else
        push_req(FN_REMOVE, pool_key[p], pool_hash[p], $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 7; i++) status_seen[i] = 0;
    empty_table();
    tbl_limit = FILL_LIMIT_RST;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, every operation, remove of an absent key
    push_req(FN_FIND, 32'h0, 32'h0, 32'h0);
    push_req(FN_REMOVE, 32'h0, 32'h0, 32'hffffffff);
    push_req(FN_INSERT, 32'h0, 32'h0, 32'h0);
    push_req(FN_INSERT, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    push_req(FN_INSERT, 32'h5a5a5a5a, 32'h000003ff, 32'ha5a5a5a5);
    push_req(FN_INSERT, 32'h12345678, 32'hfffffc00, 32'h1);
    push_req(FN_FIND, 32'hffffffff, 32'hffffffff, 32'h0);
    push_req(FN_FIND, 32'h5a5a5a5a, 32'h000003ff, 32'h0);
    push_req(FN_FIND, 32'h12345678, 32'hfffffc00, 32'h0);
    push_req(FN_INSERT, 32'h0, 32'h0, 32'hdeadbeef);
    push_req(FN_FIND, 32'h0, 32'h0, 32'h0);
    push_req(FN_REMOVE, 32'h0, 32'h0, 32'h0);
    push_req(FN_FIND, 32'h12345678, 32'hfffffc00, 32'h0);
    push_req(FN_REMOVE, 32'h77777777, 32'h3ff, 32'h0);
    push_req(FN_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    push_req(FN_FIND, 32'hffffffff, 32'hffffffff, 32'h0);

    // fill limit zero refuses every new key
    set_limit(11'd0);
    push_req(FN_INSERT, 32'h1, 32'h1, 32'h1);
    push_req(FN_FIND, 32'h1, 32'h1, 32'h0);

    // update still allowed once the limit is reached
    set_limit(11'd1);
    push_req(FN_INSERT, 32'h2, 32'h5, 32'h10);
    push_req(FN_INSERT, 32'h3, 32'h5, 32'h11);
    push_req(FN_INSERT, 32'h2, 32'h5, 32'h12);
    push_req(FN_FIND, 32'h2, 32'h5, 32'h0);
    push_req(FN_CLEAR, 32'h0, 32'h0, 32'h0);

    set_limit(11'd40);
    make_pool(56, 20);
    random_requests(300);
    set_limit(11'd1024);
    make_pool(64, 40);
    random_requests(300);
    set_limit(11'd12);
    make_pool(24, 6);
    random_requests(230);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Covered directed cases and clustered random traffic under %0d limit settings.",
             5);
    $display("Status counts: new %0d, upd %0d, found %0d, miss %0d, rm %0d, full %0d, clr %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Timeout waiting for results");
    $display("Test completed with failures");
    $finish;
  end

endmodule
